/* design/length_prefix_batch_deframer_unit_assert.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the length-prefix batch deframer
// Concurrent assertion wrappers that can be compiled out with NO_ASSERTIONS.
// ---------------------------------------------------------------------------
`ifndef LENGTH_PREFIX_BATCH_DEFRAMER_UNIT_ASSERT_SVH
`define LENGTH_PREFIX_BATCH_DEFRAMER_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define LPBD_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("lpbd assertion failed");
`define LPBD_ASSERT_NEVER(name, clk, rst, cond) \
   name: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("lpbd forbidden condition seen");
`else
`define LPBD_ASSERT(name, clk, rst, prop)
`define LPBD_ASSERT_NEVER(name, clk, rst, cond)
`endif

`endif

/* design/lpbd_pkg.sv */
// ---------------------------------------------------------------------------
// Length-prefix batch deframer package
// Transaction types and status codes shared by the deframer modules.
// ---------------------------------------------------------------------------
package lpbd_pkg;

   localparam int unsigned HDR_BYTES = 4;

   localparam logic [1:0] ST_OK          = 2'd0;
   localparam logic [1:0] ST_ZERO_LEN    = 2'd1;
   localparam logic [1:0] ST_TRUNCATED   = 2'd2;
   localparam logic [1:0] ST_PARTIAL_HDR = 2'd3;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       is_last;
   } lpbd_req_type;

   typedef struct packed {
      logic [7:0] payload_byte;
      logic       payload_valid;
      logic       packet_end;
      logic       batch_end;
      logic [1:0] batch_status;
   } lpbd_rsp_type;

   typedef struct packed {
      logic full;
      logic empty;
   } lpbd_queue_status_type;

endpackage

/* design/lpbd_front.sv */
// ---------------------------------------------------------------------------
// Deframer front end
// Accepts batch bytes, tracks header and payload state and classifies each
// byte into a result transaction for the queue.
// ---------------------------------------------------------------------------
`include "length_prefix_batch_deframer_unit_assert.svh"

module lpbd_front
   import lpbd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  lpbd_req_type req_data,
   input  logic         queue_full,
   output logic         push,
   output lpbd_rsp_type push_data
);

   logic        in_payload_ff, in_payload_in;
   logic [1:0]  header_count_ff, header_count_in;
   logic [23:0] header_shift_ff, header_shift_in;
   logic [31:0] payload_left_ff, payload_left_in;
   logic [1:0]  error_code_ff, error_code_in;
   logic [31:0] plen;
   logic [31:0] left_dec;

   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;
   assign plen      = {header_shift_ff, req_data.data_byte};
   assign left_dec  = payload_left_ff - 32'd1;

   always_comb begin
      in_payload_in   = in_payload_ff;
      header_count_in = header_count_ff;
      header_shift_in = header_shift_ff;
      payload_left_in = payload_left_ff;
      error_code_in   = error_code_ff;
      push_data       = '0;
      push_data.payload_byte = req_data.data_byte;
      push_data.batch_end    = req_data.is_last;

      if (push) begin
         priority if (error_code_ff != ST_OK) begin
            error_code_in = error_code_ff;
         end else if (!in_payload_ff) begin
            if (header_count_ff != 2'(HDR_BYTES - 1)) begin
               header_shift_in = {header_shift_ff[15:0], req_data.data_byte};
               header_count_in = header_count_ff + 2'd1;
               if (req_data.is_last) begin
                  error_code_in = ST_PARTIAL_HDR;
               end
            end else begin
               header_count_in = 2'd0;
               header_shift_in = '0;
               if (plen == 32'd0) begin
                  error_code_in = ST_ZERO_LEN;
               end else begin
                  in_payload_in   = 1'b1;
                  payload_left_in = plen;
                  if (req_data.is_last) begin
                     error_code_in = ST_TRUNCATED;
                  end
               end
            end
         end else begin
            push_data.payload_valid = 1'b1;
            payload_left_in         = left_dec;
            if (left_dec == 32'd0) begin
               push_data.packet_end = 1'b1;
               in_payload_in        = 1'b0;
            end else if (req_data.is_last) begin
               error_code_in = ST_TRUNCATED;
            end
         end

         if (req_data.is_last) begin
            push_data.batch_status = error_code_in;
            in_payload_in   = 1'b0;
            header_count_in = 2'd0;
            header_shift_in = '0;
            payload_left_in = '0;
            error_code_in   = ST_OK;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_payload_ff   <= 1'b0;
         header_count_ff <= 2'd0;
         header_shift_ff <= '0;
         payload_left_ff <= '0;
         error_code_ff   <= ST_OK;
      end else begin
         in_payload_ff   <= in_payload_in;
         header_count_ff <= header_count_in;
         header_shift_ff <= header_shift_in;
         payload_left_ff <= payload_left_in;
         error_code_ff   <= error_code_in;
      end
   end

   `LPBD_ASSERT_NEVER(a_error_outside_header, clock, reset,
      (error_code_ff != ST_OK) && in_payload_ff)
   `LPBD_ASSERT(a_batch_end_clears, clock, reset,
      push && req_data.is_last |=>
         (error_code_ff == ST_OK) && !in_payload_ff && (header_count_ff == 2'd0))
   `LPBD_ASSERT(a_payload_needs_state, clock, reset,
      push && push_data.payload_valid |-> in_payload_ff && (payload_left_ff != 32'd0))

endmodule

/* design/lpbd_queue.sv */
// ---------------------------------------------------------------------------
// Deframer transaction queue
// Small register FIFO that decouples the front end from the output stage.
// ---------------------------------------------------------------------------
`include "length_prefix_batch_deframer_unit_assert.svh"

module lpbd_queue
   import lpbd_pkg::*;
#(
   parameter int unsigned DEPTH = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  lpbd_rsp_type          push_data,
   input  logic                  pop,
   output lpbd_rsp_type          pop_data,
   output lpbd_queue_status_type status
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   lpbd_rsp_type     entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign status.full  = (count_ff == FULL_CNT);
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign pop_data     = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      unique case ({do_push, do_pop})
         2'b10:   count_in = count_ff + CNT_W'(1);
         2'b01:   count_in = count_ff - CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `LPBD_ASSERT_NEVER(a_count_bound, clock, reset, count_ff > FULL_CNT)
   `LPBD_ASSERT_NEVER(a_push_when_full, clock, reset, push && status.full)
   `LPBD_ASSERT_NEVER(a_pop_when_empty, clock, reset, pop && status.empty)

endmodule

/* design/lpbd_back.sv */
// ---------------------------------------------------------------------------
// Deframer output stage
// Drains the queue into the result register and clears fields that carry no
// meaning for the transaction.
// ---------------------------------------------------------------------------
module lpbd_back
   import lpbd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  lpbd_queue_status_type queue_status,
   input  lpbd_rsp_type          queue_data,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output lpbd_rsp_type          rsp_data
);

   logic         rsp_valid_ff, rsp_valid_in;
   lpbd_rsp_type rsp_data_ff, rsp_data_in;

   assign pop = !queue_status.empty && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      rsp_data_in = rsp_data_ff;
      if (pop) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = queue_data;
         if (!queue_data.payload_valid) begin
            rsp_data_in.payload_byte = '0;
         end
         if (!queue_data.batch_end) begin
            rsp_data_in.batch_status = ST_OK;
         end
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* design/length_prefix_batch_deframer_unit.sv */
// ---------------------------------------------------------------------------
// Length-prefix batch deframer
// Splits a byte stream of 4-byte big-endian length-prefixed packets into
// payload bytes with packet and batch boundaries and a batch status.
// ---------------------------------------------------------------------------
// Usage:
// The request channel carries one batch byte per transaction, with is_last
// on the final byte of a batch. The response channel returns exactly one
// transaction per request byte: the payload byte with payload_valid when the
// byte is packet payload, packet_end on the last byte of a packet, and
// batch_end with batch_status on the final byte of a batch.
// A failed batch still shows the payload bytes passed before the failure, so
// the consumer discards that batch's packets when batch_status is not zero.
// Throughput is one byte per clock while the queue is not full. An accepted
// byte is written into the queue and then moved into the output register,
// which presents the response.
// When the receiver stalls, the queue absorbs up to QUEUE_DEPTH transactions
// before req_stall rises; the response held in the output register does not
// change while stalled.
// Reset clears the parser state, the queue and the output valid flag; the next
// byte starts a new batch. No clearing pass is needed after reset.
// ---------------------------------------------------------------------------
module length_prefix_batch_deframer_unit
   import lpbd_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  lpbd_req_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output lpbd_rsp_type rsp_data
);

   logic                  push;
   logic                  pop;
   lpbd_rsp_type          push_data;
   lpbd_rsp_type          queue_data;
   lpbd_queue_status_type queue_status;

   lpbd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .queue_full (queue_status.full),
      .push       (push),
      .push_data  (push_data)
   );

   lpbd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (queue_data),
      .status    (queue_status)
   );

   lpbd_back u_back (
      .clock        (clock),
      .reset        (reset),
      .queue_status (queue_status),
      .queue_data   (queue_data),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data)
   );

endmodule
